/* rtl/gfm_pkg.sv */
// Shared types and constants for the GF(2^128) multiplier pipeline.
`default_nettype none

package gfm_pkg;

  localparam int OP_BITS = 128;
  localparam int HALF_BITS = 64;

  // x^128 = x^7 + x^2 + x + 1 folded back into the low bits
  localparam logic [OP_BITS-1:0] REDUCE_POLY = 128'h87;

  // Working set carried from cell to cell
  typedef struct packed {
    logic [OP_BITS-1:0] acc;  // partial product
    logic [OP_BITS-1:0] a;    // first operand times x^k, reduced
    logic [OP_BITS-1:0] b;    // second operand bits not yet consumed, at the bottom
  } gfm_word_t;

endpackage

`default_nettype wire

/* rtl/gfm_cell.sv */
// One pipeline cell: consumes a few multiplier bits and hands the result onward.
`default_nettype none

module gfm_cell #(
  parameter int STEPS = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               up_valid,
  output logic              up_ready,
  input  wire gfm_pkg::gfm_word_t up_data,
  output logic              dn_valid,
  input  wire               dn_ready,
  output gfm_pkg::gfm_word_t dn_data
);
  import gfm_pkg::*;

  logic      valid_r, valid_nxt;
  gfm_word_t data_r, data_nxt;
  logic      accept;

  assign up_ready = !valid_r || dn_ready;
  assign accept   = up_valid && up_ready;

  always_comb begin
    logic [OP_BITS-1:0] acc_w;
    logic [OP_BITS-1:0] a_w;
    acc_w = up_data.acc;
    a_w   = up_data.a;
    for (int s = 0; s < STEPS; s++) begin
      if (up_data.b[s]) begin
        acc_w = acc_w ^ a_w;
      end
      // multiply by x, fold the bit leaving the top back in
      a_w = {a_w[OP_BITS-2:0], 1'b0} ^ (a_w[OP_BITS-1] ? REDUCE_POLY : '0);
    end
    data_nxt.acc = acc_w;
    data_nxt.a   = a_w;
    data_nxt.b   = up_data.b >> STEPS;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (dn_valid && !dn_ready) |=> (dn_valid && $stable(dn_data.acc)))
    else $error("cell lost or changed a stalled transaction");

  a_zero_multiple: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && up_data.a == '0) |=> (dn_data.a == '0))
    else $error("zero multiple became nonzero");

  a_no_bits_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && up_data.b[STEPS-1:0] == '0) |=> (dn_data.acc == $past(up_data.acc)))
    else $error("accumulator changed with no multiplier bits set");
`endif

endmodule

`default_nettype wire

/* rtl/gf128_multiplier_core.sv */
// Top level: GF(2^128) multiplier built as a chain of bit-slice cells.
//
// Usage:
//   The input channel (in_tvalid/in_tready/in_tdata) takes one operand pair per
//   transaction; the output channel (out_tvalid/out_tready/out_tdata) returns
//   the product reduced modulo x^128 + x^7 + x^2 + x + 1. Bit i is the
//   coefficient of x^i.
//   Each product passes through one register stage per cell between the input
//   transaction and the output transaction.
//   Throughput: one transaction per cycle while out_tready stays high; each cell
//   holds one item, so up to 128 / BITS_PER_CELL products are in flight at once.
//   The depth of the cell chain sets the latency; the bits handled per cell
//   set the logic depth between registers.
//   Stall: when out_tready is low, the last cell holds its product and the
//   cells behind it fill up; in_tready drops only when every cell is full.
//   Reset (rst_n low, synchronous) empties the chain; items in flight are
//   dropped.
`default_nettype none

module gf128_multiplier_core #(
  parameter int BITS_PER_CELL = 4  // must divide 128, at most 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // a_low [63:0], a_high [127:64], b_low [191:128], b_high [255:192]
  input  wire  [255:0] in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // product_low [63:0], product_high [127:64]
  output logic [127:0] out_tdata
);
  import gfm_pkg::*;

  localparam int NUM_CELLS = OP_BITS / BITS_PER_CELL;

  logic      link_valid [0:NUM_CELLS];
  logic      link_ready [0:NUM_CELLS];
  gfm_word_t link_data  [0:NUM_CELLS];

  assign link_valid[0]  = in_tvalid;
  assign in_tready      = link_ready[0];
  // empty accumulator, first operand, second operand
  assign link_data[0]   = {{OP_BITS{1'b0}}, in_tdata[OP_BITS-1:0],
                           in_tdata[2*OP_BITS-1:OP_BITS]};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gfm_cell #(
      .STEPS (BITS_PER_CELL)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up_data  (link_data[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn_data  (link_data[i+1])
    );
  end

  assign link_ready[NUM_CELLS] = out_tready;
  assign out_tvalid = link_valid[NUM_CELLS];
  assign out_tdata  = {link_data[NUM_CELLS].acc[OP_BITS-1:HALF_BITS],
                       link_data[NUM_CELLS].acc[HALF_BITS-1:0]};

endmodule

`default_nettype wire
